// ===== src/rad_pkg.sv =====
// Shared constants and types for the AVI movi chunk demultiplexer.
`timescale 1ns / 1ps
`default_nettype none

package rad_pkg;

  // Stream field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned WordW  = 32;

  // Bytes of RIFF file header dropped at the start of the stream
  localparam logic [WordW-1:0] RiffHdrBytes = 32'd12;
  // Bytes in a chunk header (id then size) and in a list type
  localparam logic [WordW-1:0] ChunkHdrBytes = 32'd8;
  localparam logic [WordW-1:0] FourccBytes   = 32'd4;

  // FourCC codes, first byte in the top bits
  localparam logic [WordW-1:0] IdList = 32'h4C49_5354;  // "LIST"
  localparam logic [WordW-1:0] IdMovi = 32'h6D6F_7669;  // "movi"

  // Stream type characters of a movi chunk id
  localparam logic [ByteW-1:0] ChD = 8'h64;  // 'd'
  localparam logic [ByteW-1:0] ChB = 8'h62;  // 'b'
  localparam logic [ByteW-1:0] ChC = 8'h63;  // 'c'

  // One result word from the parser
  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
    logic [WordW-1:0] frame_bytes;
    logic             last;
  } rad_res_t;

endpackage

`default_nettype wire

// ===== src/rad_parser.sv =====
// Chunk parser: walks the RIFF/AVI structure one byte per accepted word.
`timescale 1ns / 1ps
`default_nettype none

module rad_parser
  import rad_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             accept,
  input  wire logic [ByteW-1:0] in_byte,
  output rad_res_t              res
);

  typedef enum logic [2:0] {
    PH_HDR_SKIP  = 3'd0,
    PH_TOP_HDR   = 3'd1,
    PH_LIST_TYPE = 3'd2,
    PH_SKIP      = 3'd3,
    PH_MOVI_HDR  = 3'd4,
    PH_FRAME     = 3'd5
  } phase_t;

  phase_t           phase, phase_next;
  logic [WordW-1:0] byte_cnt, byte_cnt_next;
  logic [WordW-1:0] id_shift, id_shift_next;
  logic [WordW-1:0] chunk_len, chunk_len_next;
  logic             in_movi, in_movi_next;

  // Shared helper terms
  logic [WordW-1:0] cnt_inc, cnt_dec, id_upd, len_upd, list_skip;
  logic             hdr_done, is_video;
  phase_t           hdr_phase;

  always_comb begin
    cnt_inc   = byte_cnt + 32'd1;
    cnt_dec   = (byte_cnt != '0) ? byte_cnt - 32'd1 : byte_cnt;
    hdr_phase = in_movi ? PH_MOVI_HDR : PH_TOP_HDR;
    // id bytes first, then little-endian size bytes
    if (byte_cnt < FourccBytes) begin
      id_upd  = {id_shift[WordW-ByteW-1:0], in_byte};
      len_upd = chunk_len;
    end else begin
      id_upd  = id_shift;
      len_upd = {in_byte, chunk_len[WordW-1:ByteW]};
    end
    hdr_done  = (cnt_inc >= ChunkHdrBytes);
    is_video  = (id_upd[15:8] == ChD) && ((id_upd[7:0] == ChB) || (id_upd[7:0] == ChC));
    // short LIST saturates to an empty skip
    list_skip = (chunk_len >= FourccBytes) ? chunk_len - FourccBytes : '0;
  end

  // Next-state logic
  always_comb begin
    phase_next     = phase;
    byte_cnt_next  = byte_cnt;
    id_shift_next  = id_shift;
    chunk_len_next = chunk_len;
    in_movi_next   = in_movi;
    res            = '0;
    case (phase)
      PH_TOP_HDR: begin
        id_shift_next  = id_upd;
        chunk_len_next = len_upd;
        byte_cnt_next  = cnt_inc;
        if (hdr_done) begin
          if (id_upd == IdList) begin
            byte_cnt_next = '0;
            phase_next    = PH_LIST_TYPE;
          end else begin
            byte_cnt_next = len_upd;
            phase_next    = (len_upd == '0) ? hdr_phase : PH_SKIP;
          end
        end
      end
      PH_LIST_TYPE: begin
        id_shift_next = {id_shift[WordW-ByteW-1:0], in_byte};
        byte_cnt_next = cnt_inc;
        if (cnt_inc >= FourccBytes) begin
          if (id_shift_next == IdMovi) begin
            byte_cnt_next = '0;
            in_movi_next  = 1'b1;
            phase_next    = PH_MOVI_HDR;
          end else begin
            byte_cnt_next = list_skip;
            phase_next    = (list_skip == '0) ? hdr_phase : PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        byte_cnt_next = cnt_dec;
        if (cnt_dec == '0) begin
          phase_next = hdr_phase;
        end
      end
      PH_MOVI_HDR: begin
        id_shift_next  = id_upd;
        chunk_len_next = len_upd;
        byte_cnt_next  = cnt_inc;
        if (hdr_done) begin
          byte_cnt_next = len_upd;
          if (is_video) begin
            // empty frame goes straight to the next chunk header
            phase_next = (len_upd == '0) ? PH_MOVI_HDR : PH_FRAME;
          end else begin
            phase_next = (len_upd == '0) ? hdr_phase : PH_SKIP;
          end
        end
      end
      PH_FRAME: begin
        byte_cnt_next   = cnt_dec;
        res.valid       = 1'b1;
        res.data        = in_byte;
        res.frame_bytes = chunk_len;
        res.last        = (cnt_dec == '0);
        if (cnt_dec == '0) begin
          phase_next = PH_MOVI_HDR;
        end
      end
      default: begin
        // RIFF header skip
        byte_cnt_next = cnt_inc;
        if (cnt_inc >= RiffHdrBytes) begin
          byte_cnt_next = '0;
          phase_next    = PH_TOP_HDR;
        end else begin
          phase_next = PH_HDR_SKIP;
        end
      end
    endcase
  end

  // State registers, advanced once per accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HDR_SKIP;
      byte_cnt  <= '0;
      id_shift  <= '0;
      chunk_len <= '0;
      in_movi   <= 1'b0;
    end else if (accept) begin
      phase     <= phase_next;
      byte_cnt  <= byte_cnt_next;
      id_shift  <= id_shift_next;
      chunk_len <= chunk_len_next;
      in_movi   <= in_movi_next;
    end
  end

endmodule

`default_nettype wire

// ===== src/riff_avi_chunk_demux.sv =====
// Top level: AVI byte stream in, video frame payload bytes out.
//
// Input stream: one file byte per word on s_axis_tdata[7:0]. The 12-byte
// RIFF header is dropped, top-level chunks are skipped until LIST movi,
// and inside movi every 'db'/'dc' chunk has its payload passed on.
// Output stream: one payload byte per word, with the frame's chunk size
// alongside it and tlast on the final byte of each frame. Other chunks,
// headers and empty frames produce no output words.
// A payload byte appears on the output the cycle after it is accepted.
// Throughput: one byte per cycle while the receiver keeps up, set by the
// single output register; the parser updates state in the cycle of acceptance.
// Reset (rst, synchronous) returns the parser to the RIFF header skip and
// empties the output register.
// When the receiver stalls with a word held, s_axis_tready falls and the
// held word stays unchanged; input is taken again in the cycle the held
// word is taken.
`timescale 1ns / 1ps
`default_nettype none

module riff_avi_chunk_demux
  import rad_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_axis_tvalid,
  output      logic                   s_axis_tready,
  input  wire logic [ByteW-1:0]       s_axis_tdata,   // [7:0] in_byte
  output      logic                   m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  output      logic [ByteW+WordW-1:0] m_axis_tdata,   // [7:0] out_byte, [39:8] frame_bytes
  output      logic                   m_axis_tlast    // frame_last
);

  logic     accept;
  rad_res_t res;

  // Take a word whenever the output slot is free or being emptied
  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  rad_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_byte (s_axis_tdata),
    .res     (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (accept) begin
      m_axis_tvalid <= res.valid;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      m_axis_tdata <= {res.frame_bytes, res.data};
      m_axis_tlast <= res.last;
    end
  end

endmodule

`default_nettype wire
